// File: src/mde_pkg.sv
// ---------------------------------------------------------------------------
// mde_pkg
// Shared types and codes for the MIPS decode and execute unit: the command
// and result transactions, the stage-to-stage bundles, opcode and funct
// codes, ALU operation codes and next-PC control codes.
// ---------------------------------------------------------------------------
`default_nettype none

package mde_pkg;

  // command transaction: one instruction with its operands
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } mde_cmd_t;

  // result transaction
  typedef struct packed {
    logic [31:0] alu_value;
    logic [4:0]  dest_reg;
    logic        wb_en;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [31:0] next_pc;
    logic        illegal;
  } mde_res_t;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // special funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // regimm rt codes
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  // link and zero registers
  localparam logic [4:0] REG_LINK = 5'd31;
  localparam logic [4:0] REG_ZERO = 5'd0;

  // memory access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // alu operations
  localparam logic [3:0] ALU_ZERO = 4'd0;
  localparam logic [3:0] ALU_ADD  = 4'd1;
  localparam logic [3:0] ALU_SUB  = 4'd2;
  localparam logic [3:0] ALU_AND  = 4'd3;
  localparam logic [3:0] ALU_OR   = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_NOR  = 4'd6;
  localparam logic [3:0] ALU_SLT  = 4'd7;
  localparam logic [3:0] ALU_SLTU = 4'd8;
  localparam logic [3:0] ALU_SLL  = 4'd9;
  localparam logic [3:0] ALU_SRL  = 4'd10;
  localparam logic [3:0] ALU_SRA  = 4'd11;
  localparam logic [3:0] ALU_PASS = 4'd12;

  // source of the redirect address
  localparam logic [1:0] NPC_SEQ  = 2'd0;
  localparam logic [1:0] NPC_BR   = 2'd1;
  localparam logic [1:0] NPC_JUMP = 2'd2;
  localparam logic [1:0] NPC_REG  = 2'd3;

  // redirect conditions
  localparam logic [2:0] BR_NONE   = 3'd0;
  localparam logic [2:0] BR_EQ     = 3'd1;
  localparam logic [2:0] BR_NE     = 3'd2;
  localparam logic [2:0] BR_LEZ    = 3'd3;
  localparam logic [2:0] BR_GTZ    = 3'd4;
  localparam logic [2:0] BR_LTZ    = 3'd5;
  localparam logic [2:0] BR_GEZ    = 3'd6;
  localparam logic [2:0] BR_ALWAYS = 3'd7;

  // decode stage bundle
  typedef struct packed {
    logic        valid;
    logic [3:0]  alu_op;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [4:0]  dest_reg;
    logic        wb_en;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [31:0] pc4;
    logic [31:0] tgt;
    logic [1:0]  npc_src;
    logic [2:0]  br_kind;
    logic        illegal;
  } mde_dec_t;

  // execute stage bundle
  typedef struct packed {
    logic        valid;
    logic [31:0] alu_value;
    logic [4:0]  dest_reg;
    logic        wb_en;
    logic        mem_read;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [31:0] pc4;
    logic [31:0] alt_pc;
    logic [2:0]  br_kind;
    logic        a_eq_b;
    logic        a_neg;
    logic        a_zero;
    logic        illegal;
  } mde_exe_t;

endpackage

`default_nettype wire

// File: src/mde_decode.sv
// ---------------------------------------------------------------------------
// mde_decode
// First pipeline stage: splits the instruction word, selects ALU operands,
// destination and memory controls, forms pc+4 and the jump or branch
// offset, and flags unsupported encodings.
// ---------------------------------------------------------------------------
`default_nettype none

module mde_decode
  import mde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire mde_cmd_t cmd,
  output mde_dec_t      dec
);

  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  mde_dec_t    dec_next;

  // instruction fields
  assign op   = cmd.instr_word[31:26];
  assign rt   = cmd.instr_word[20:16];
  assign rd   = cmd.instr_word[15:11];
  assign fn   = cmd.instr_word[5:0];
  assign imm  = cmd.instr_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};
  assign pc4  = cmd.pc + 32'd4;

  // control decode
  always_comb begin
    dec_next            = '0;
    dec_next.valid      = in_valid;
    dec_next.alu_op     = ALU_ZERO;
    dec_next.opa        = cmd.rs_value;
    dec_next.opb        = cmd.rt_value;
    dec_next.shamt      = cmd.instr_word[10:6];
    dec_next.dest_reg   = REG_ZERO;
    dec_next.mem_size   = SZ_BYTE;
    dec_next.pc4        = pc4;
    dec_next.tgt        = {simm[29:0], 2'b00};
    dec_next.npc_src    = NPC_SEQ;
    dec_next.br_kind    = BR_NONE;

    unique case (op) inside
      OP_SPECIAL: begin
        dec_next.dest_reg = rd;
        dec_next.wb_en    = 1'b1;
        unique case (fn) inside
          FN_ADD, FN_ADDU: dec_next.alu_op = ALU_ADD;
          FN_SUB, FN_SUBU: dec_next.alu_op = ALU_SUB;
          FN_AND:  dec_next.alu_op = ALU_AND;
          FN_OR:   dec_next.alu_op = ALU_OR;
          FN_XOR:  dec_next.alu_op = ALU_XOR;
          FN_NOR:  dec_next.alu_op = ALU_NOR;
          FN_SLT:  dec_next.alu_op = ALU_SLT;
          FN_SLTU: dec_next.alu_op = ALU_SLTU;
          FN_SLL:  dec_next.alu_op = ALU_SLL;
          FN_SRL:  dec_next.alu_op = ALU_SRL;
          FN_SRA:  dec_next.alu_op = ALU_SRA;
          FN_JR: begin
            dec_next.dest_reg = REG_ZERO;
            dec_next.wb_en    = 1'b0;
            dec_next.npc_src  = NPC_REG;
            dec_next.br_kind  = BR_ALWAYS;
          end
          FN_JALR: begin
            dec_next.dest_reg = REG_LINK;
            dec_next.alu_op   = ALU_PASS;
            dec_next.opb      = pc4;
            dec_next.npc_src  = NPC_REG;
            dec_next.br_kind  = BR_ALWAYS;
          end
          default: dec_next.illegal = 1'b1;
        endcase
      end
      OP_J: begin
        dec_next.tgt     = {pc4[31:28], cmd.instr_word[25:0], 2'b00};
        dec_next.npc_src = NPC_JUMP;
        dec_next.br_kind = BR_ALWAYS;
      end
      OP_JAL: begin
        dec_next.tgt      = {pc4[31:28], cmd.instr_word[25:0], 2'b00};
        dec_next.npc_src  = NPC_JUMP;
        dec_next.br_kind  = BR_ALWAYS;
        dec_next.dest_reg = REG_LINK;
        dec_next.wb_en    = 1'b1;
        dec_next.alu_op   = ALU_PASS;
        dec_next.opb      = pc4;
      end
      OP_REGIMM, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        dec_next.alu_op  = ALU_SUB;
        dec_next.npc_src = NPC_BR;
        unique case (op)
          OP_BEQ:  dec_next.br_kind = BR_EQ;
          OP_BNE:  dec_next.br_kind = BR_NE;
          OP_BLEZ: dec_next.br_kind = BR_LEZ;
          OP_BGTZ: dec_next.br_kind = BR_GTZ;
          default: begin
            if (rt == RT_BLTZ) begin
              dec_next.br_kind = BR_LTZ;
            end else if (rt == RT_BGEZ) begin
              dec_next.br_kind = BR_GEZ;
            end else begin
              dec_next.illegal = 1'b1;
            end
          end
        endcase
      end
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        dec_next.dest_reg = rt;
        dec_next.wb_en    = 1'b1;
        dec_next.opb      = simm;
        unique case (op) inside
          OP_ADDI, OP_ADDIU: dec_next.alu_op = ALU_ADD;
          OP_SLTI:  dec_next.alu_op = ALU_SLT;
          OP_SLTIU: dec_next.alu_op = ALU_SLTU;
          OP_ANDI: begin
            dec_next.alu_op = ALU_AND;
            dec_next.opb    = zimm;
          end
          OP_ORI: begin
            dec_next.alu_op = ALU_OR;
            dec_next.opb    = zimm;
          end
          OP_XORI: begin
            dec_next.alu_op = ALU_XOR;
            dec_next.opb    = zimm;
          end
          default: begin
            dec_next.alu_op = ALU_PASS;
            dec_next.opb    = {imm, 16'h0000};
          end
        endcase
      end
      OP_LW, OP_LBU, OP_LHU: begin
        dec_next.alu_op   = ALU_ADD;
        dec_next.opb      = simm;
        dec_next.dest_reg = rt;
        dec_next.wb_en    = 1'b1;
        dec_next.mem_read = 1'b1;
        dec_next.mem_size = (op == OP_LW) ? SZ_WORD :
                            (op == OP_LBU) ? SZ_BYTE : SZ_HALF;
      end
      OP_SB, OP_SH, OP_SW: begin
        dec_next.alu_op     = ALU_ADD;
        dec_next.opb        = simm;
        dec_next.mem_write  = 1'b1;
        dec_next.store_data = cmd.rt_value;
        dec_next.mem_size   = (op == OP_SW) ? SZ_WORD :
                              (op == OP_SB) ? SZ_BYTE : SZ_HALF;
      end
      default: dec_next.illegal = 1'b1;
    endcase

    // unsupported encodings produce an all-quiet result with a sequential pc
    if (dec_next.illegal) begin
      dec_next.alu_op     = ALU_ZERO;
      dec_next.dest_reg   = REG_ZERO;
      dec_next.wb_en      = 1'b0;
      dec_next.mem_read   = 1'b0;
      dec_next.mem_write  = 1'b0;
      dec_next.mem_size   = SZ_BYTE;
      dec_next.store_data = '0;
      dec_next.npc_src    = NPC_SEQ;
      dec_next.br_kind    = BR_NONE;
    end

    // writes to r0 are dropped
    if (dec_next.dest_reg == REG_ZERO) begin
      dec_next.wb_en = 1'b0;
    end
  end

  // stage register, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= '0;
    end else begin
      dec <= dec_next;
    end
  end

endmodule

`default_nettype wire

// File: src/mde_execute.sv
// ---------------------------------------------------------------------------
// mde_execute
// Second pipeline stage: runs the ALU, forms the branch target and the
// redirect address, and captures the operand flags that branch conditions
// need.
// ---------------------------------------------------------------------------
`default_nettype none

module mde_execute
  import mde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mde_dec_t dec,
  output mde_exe_t      exe
);

  logic [31:0] alu_out;
  logic [31:0] alt_pc;
  mde_exe_t    exe_next;

  // alu
  always_comb begin
    unique case (dec.alu_op)
      ALU_ADD:  alu_out = dec.opa + dec.opb;
      ALU_SUB:  alu_out = dec.opa - dec.opb;
      ALU_AND:  alu_out = dec.opa & dec.opb;
      ALU_OR:   alu_out = dec.opa | dec.opb;
      ALU_XOR:  alu_out = dec.opa ^ dec.opb;
      ALU_NOR:  alu_out = ~(dec.opa | dec.opb);
      ALU_SLT:  alu_out = {31'b0, $signed(dec.opa) < $signed(dec.opb)};
      ALU_SLTU: alu_out = {31'b0, dec.opa < dec.opb};
      ALU_SLL:  alu_out = dec.opb << dec.shamt;
      ALU_SRL:  alu_out = dec.opb >> dec.shamt;
      ALU_SRA:  alu_out = 32'($signed(dec.opb) >>> dec.shamt);
      ALU_PASS: alu_out = dec.opb;
      default:  alu_out = '0;
    endcase
  end

  // redirect address
  always_comb begin
    unique case (dec.npc_src)
      NPC_BR:   alt_pc = dec.pc4 + dec.tgt;
      NPC_JUMP: alt_pc = dec.tgt;
      NPC_REG:  alt_pc = dec.opa;
      default:  alt_pc = dec.pc4;
    endcase
  end

  // stage bundle
  always_comb begin
    exe_next.valid      = dec.valid;
    exe_next.alu_value  = alu_out;
    exe_next.dest_reg   = dec.dest_reg;
    exe_next.wb_en      = dec.wb_en;
    exe_next.mem_read   = dec.mem_read;
    exe_next.mem_write  = dec.mem_write;
    exe_next.mem_size   = dec.mem_size;
    exe_next.store_data = dec.store_data;
    exe_next.pc4        = dec.pc4;
    exe_next.alt_pc     = alt_pc;
    exe_next.br_kind    = dec.br_kind;
    exe_next.a_eq_b     = (dec.opa == dec.opb);
    exe_next.a_neg      = dec.opa[31];
    exe_next.a_zero     = (dec.opa == '0);
    exe_next.illegal    = dec.illegal;
  end

  // stage register, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      exe <= '0;
    end else begin
      exe <= exe_next;
    end
  end

endmodule

`default_nettype wire

// File: src/mde_resolve.sv
// ---------------------------------------------------------------------------
// mde_resolve
// Third pipeline stage: evaluates the branch condition, picks the next pc
// and registers the finished result with its strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module mde_resolve
  import mde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mde_exe_t exe,
  output logic          done,
  output mde_res_t      result
);

  logic     taken;
  mde_res_t result_next;

  // branch condition
  always_comb begin
    unique case (exe.br_kind)
      BR_EQ:     taken = exe.a_eq_b;
      BR_NE:     taken = !exe.a_eq_b;
      BR_LEZ:    taken = exe.a_neg || exe.a_zero;
      BR_GTZ:    taken = !exe.a_neg && !exe.a_zero;
      BR_LTZ:    taken = exe.a_neg;
      BR_GEZ:    taken = !exe.a_neg;
      BR_ALWAYS: taken = 1'b1;
      default:   taken = 1'b0;
    endcase
  end

  // result assembly
  always_comb begin
    result_next.alu_value  = exe.alu_value;
    result_next.dest_reg   = exe.dest_reg;
    result_next.wb_en      = exe.wb_en;
    result_next.mem_read   = exe.mem_read;
    result_next.mem_write  = exe.mem_write;
    result_next.mem_size   = exe.mem_size;
    result_next.store_data = exe.store_data;
    result_next.next_pc    = taken ? exe.alt_pc : exe.pc4;
    result_next.illegal    = exe.illegal;
  end

  // output register
  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exe.valid;
    end
  end

endmodule

`default_nettype wire

// File: src/mips_decode_execute_unit.sv
// ---------------------------------------------------------------------------
// mips_decode_execute_unit
// A result strobes on done after the decode, execute and resolve registers.
// Throughput: one instruction per cycle through decode, execute and resolve.
// Each stage holds one register level; the receiver cannot stall, so busy
// is only high while rst is asserted.
// Reset clears the decode and execute stage registers and done; the result
// payload is not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module mips_decode_execute_unit
  import mde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire mde_cmd_t cmd,
  output logic          done,
  output mde_res_t      result
);

  logic     accept;
  mde_dec_t dec;
  mde_exe_t exe;

  // command transaction handshake
  assign busy   = rst;
  assign accept = start && !busy;

  mde_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .cmd      (cmd),
    .dec      (dec)
  );

  mde_execute u_execute (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .exe (exe)
  );

  mde_resolve u_resolve (
    .clk    (clk),
    .rst    (rst),
    .exe    (exe),
    .done   (done),
    .result (result)
  );

  // every accepted transaction later yields a result on done
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted transaction did not complete on time");

  // every result comes from an earlier accepted transaction
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without matching transaction");

  // illegal instructions fall through to pc+4
  a_illegal_seq : assert property (@(posedge clk) disable iff (rst)
    (done && result.illegal) |-> (result.next_pc == $past(cmd.pc, 3) + 32'd4))
    else $error("illegal instruction redirected the pc");

  // stores carry the rt value of their own transaction
  a_store_data : assert property (@(posedge clk) disable iff (rst)
    (done && result.mem_write) |-> (result.store_data == $past(cmd.rt_value, 3)))
    else $error("store data does not match its transaction");

endmodule

`default_nettype wire
